/* hdl/lslf_pkg.sv */
// Shared types and constants for the least-squares line fit block.
package lslf_pkg;

    // Fixed field widths of the point and result items
    localparam int XW = 10;
    localparam int YW = 32;
    localparam int QW = 32;

    // Fit outcome reported with each result
    typedef enum logic [1:0] {
        FIT_OK       = 2'd0,
        FIT_ZERO_DEN = 2'd1,
        FIT_OVERFLOW = 2'd2
    } t_fit_status;

    // Command to the shared multiply-accumulate unit
    typedef struct packed {
        logic start;
        logic clr;
        logic sub;
    } t_mac_ctl;

endpackage

/* hdl/lslf_mac.sv */
// Shift-add multiply-accumulate unit: acc = (clr ? 0 : acc) +/- a * b, one bit of b a cycle.
module lslf_mac #(
    parameter int AW = 46,
    parameter int BW = 24,
    parameter int NW = 71
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lslf_pkg::t_mac_ctl   i_ctl,
    input  logic signed [AW-1:0] i_a,
    input  logic        [BW-1:0] i_b,
    output logic                 o_done,
    output logic signed [NW-1:0] o_acc
);

    logic                 r_busy;
    logic                 r_sub;
    logic signed [NW-1:0] r_acc;
    logic signed [NW-1:0] r_m;
    logic        [BW-1:0] r_b;

    // Finish once no multiplier bits remain
    assign o_done = r_busy && (r_b == '0);
    assign o_acc  = r_acc;

    // Control: busy from start until the multiplier is used up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // Datapath: add or subtract the shifted multiplicand for each set bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_m   <= NW'(i_a);
            r_b   <= i_b;
            r_sub <= i_ctl.sub;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_acc <= r_sub ? (r_acc - r_m) : (r_acc + r_m);
            end
            r_m <= r_m <<< 1;
            r_b <= r_b >> 1;
        end
    end

endmodule

/* hdl/lslf_div.sv */
// Restoring divider: signed numerator over positive denominator, truncated, saturated.
module lslf_div #(
    parameter int NW = 71,
    parameter int DW = 28
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [NW-1:0]             i_num,
    input  logic        [DW-1:0]             i_den,
    output logic                             o_done,
    output logic signed [lslf_pkg::QW-1:0]   o_quot
);

    localparam int CNTW = $clog2(NW + 1);
    localparam int QW   = lslf_pkg::QW;

    logic            r_busy;
    logic [CNTW-1:0] r_cnt;
    logic            r_neg;
    logic [NW-1:0]   r_num;
    logic [DW-1:0]   r_den;
    logic [DW-1:0]   r_rem;
    logic [QW:0]     r_q;
    logic            r_sticky;

    logic [DW:0]     shifted;
    logic            fits;
    logic            over;
    logic [QW:0]     limit;

    // Trial subtract of one numerator bit
    assign shifted = {r_rem, r_num[NW-1]};
    assign fits    = shifted >= {1'b0, r_den};

    assign o_done = r_busy && (r_cnt == '0);

    // Saturate the magnitude to the signed 32-bit range
    assign limit = r_neg ? {1'b0, 1'b1, {(QW-1){1'b0}}} : {2'b00, {(QW-1){1'b1}}};
    assign over  = r_sticky || (r_q > limit);

    always_comb begin
        if (over) begin
            o_quot = r_neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end else begin
            o_quot = r_neg ? -$signed(r_q[QW-1:0]) : $signed(r_q[QW-1:0]);
        end
    end

    // Control: count one step per numerator bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(NW);
        end else if (o_done) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Datapath: take the magnitude, then shift and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg    <= i_num[NW-1];
            r_num    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_den    <= i_den;
            r_rem    <= '0;
            r_q      <= '0;
            r_sticky <= 1'b0;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem    <= fits ? DW'(shifted - {1'b0, r_den}) : shifted[DW-1:0];
            r_num    <= r_num << 1;
            r_sticky <= r_sticky | r_q[QW];
            r_q      <= {r_q[QW-1:0], fits};
        end
    end

endmodule

/* hdl/least_squares_line_fit.sv */
// Top level of the least-squares line fit: point accumulation, fit sequencer, output stage.
//
// Each request carries one point (x in tdata[9:0], Q16.16 y in tdata[41:10]); tlast ends
// the set. A point passes the accept, product and accumulate steps before the next request is
// taken; the first MAX_POINTS points of a set are summed and later ones only flag status 2.
// A last point then runs the fit on one shift-add multiply-accumulate unit and one restoring
// divider, both bit-serial: up to six multiply passes over a multiplier of at most BW bits
// (BW is the width of the sum of x squared, 24 bits at MAX_POINTS = 16) and two divisions of
// an NW-bit numerator (NW = 71 at MAX_POINTS = 16); a single point or an all-equal x set
// skips the divisions. The result goes out on tdata (slope low, intercept high) with
// the fit status on tuser, held in an output register so a new set can start while it waits.
module least_squares_line_fit #(
    parameter int MAX_POINTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [9:0] x_value, [41:10] y_value
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] slope_out, [63:32] intercept_out
    output logic [1:0]  m_axis_tuser    // [1:0] fit_status
);

    localparam int XW   = lslf_pkg::XW;
    localparam int YW   = lslf_pkg::YW;
    localparam int QW   = lslf_pkg::QW;
    localparam int LG   = $clog2(MAX_POINTS);
    localparam int CW   = $clog2(MAX_POINTS + 1);
    localparam int SXW  = $clog2(64'(MAX_POINTS) * 64'd1023 + 64'd1);
    localparam int SXXW = $clog2(64'(MAX_POINTS) * 64'd1046529 + 64'd1);
    localparam int SYW  = YW + LG;
    localparam int PXYW = XW + YW;
    localparam int SXYW = PXYW + LG;
    localparam int DW   = $clog2(64'(MAX_POINTS) * 64'(MAX_POINTS) * 64'd1046529 + 64'd1);
    localparam int AW   = SXYW;
    localparam int BW   = SXXW;
    localparam int NW   = AW + BW + 1;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_PROD     = 10'b0000000010,
        S_ACCUM    = 10'b0000000100,
        S_FIT      = 10'b0000001000,
        S_MAC_GO   = 10'b0000010000,
        S_MAC_WAIT = 10'b0000100000,
        S_CHECK    = 10'b0001000000,
        S_DIV_GO   = 10'b0010000000,
        S_DIV_WAIT = 10'b0100000000,
        S_OUT      = 10'b1000000000
    } t_state;

    // Multiply-accumulate passes of the fit
    typedef enum logic [2:0] {
        OP_DEN_A = 3'd0,
        OP_DEN_B = 3'd1,
        OP_SLO_A = 3'd2,
        OP_SLO_B = 3'd3,
        OP_INT_A = 3'd4,
        OP_INT_B = 3'd5
    } t_op;

    t_state                  r_state, n_state;
    t_op                     r_op;

    logic        [XW-1:0]    r_x;
    logic signed [YW-1:0]    r_y;
    logic                    r_last;
    logic        [2*XW-1:0]  r_pxx;
    logic signed [PXYW-1:0]  r_pxy;

    logic        [CW-1:0]    r_count;
    logic        [SXW-1:0]   r_sum_x;
    logic        [SXXW-1:0]  r_sum_xx;
    logic signed [SYW-1:0]   r_sum_y;
    logic signed [SXYW-1:0]  r_sum_xy;
    logic                    r_ovf;

    logic        [DW-1:0]    r_den;
    logic signed [QW-1:0]    r_slope;
    logic signed [QW-1:0]    r_icpt;
    lslf_pkg::t_fit_status   r_status;

    logic                    r_ovalid;
    logic signed [QW-1:0]    r_slope_o;
    logic signed [QW-1:0]    r_icpt_o;
    lslf_pkg::t_fit_status   r_status_o;

    lslf_pkg::t_mac_ctl      mac_ctl;
    logic signed [AW-1:0]    mac_a;
    logic        [BW-1:0]    mac_b;
    logic                    mac_done;
    logic signed [NW-1:0]    mac_acc;
    logic                    div_done;
    logic signed [QW-1:0]    div_quot;
    logic                    out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_icpt_o, r_slope_o};
    assign m_axis_tuser  = r_status_o;
    assign out_load      = (r_state == S_OUT) && (!r_ovalid || m_axis_tready);

    // Select operands for the current multiply pass
    always_comb begin
        mac_ctl.start = (r_state == S_MAC_GO);
        mac_ctl.clr   = 1'b0;
        mac_ctl.sub   = 1'b0;
        mac_a         = r_sum_xy;
        mac_b         = BW'(r_count);
        case (r_op)
            OP_DEN_A: begin
                mac_ctl.clr = 1'b1;
                mac_a       = AW'($signed({1'b0, r_sum_xx}));
                mac_b       = BW'(r_count);
            end
            OP_DEN_B: begin
                mac_ctl.sub = 1'b1;
                mac_a       = AW'($signed({1'b0, r_sum_x}));
                mac_b       = BW'(r_sum_x);
            end
            OP_SLO_A: begin
                mac_ctl.clr = 1'b1;
                mac_a       = r_sum_xy;
                mac_b       = BW'(r_count);
            end
            OP_SLO_B: begin
                mac_ctl.sub = 1'b1;
                mac_a       = AW'(r_sum_y);
                mac_b       = BW'(r_sum_x);
            end
            OP_INT_A: begin
                mac_ctl.clr = 1'b1;
                mac_a       = AW'(r_sum_y);
                mac_b       = r_sum_xx;
            end
            OP_INT_B: begin
                mac_ctl.sub = 1'b1;
                mac_a       = r_sum_xy;
                mac_b       = BW'(r_sum_x);
            end
            default: begin
                mac_ctl.clr = 1'b0;
            end
        endcase
    end

    lslf_mac #(
        .AW (AW),
        .BW (BW),
        .NW (NW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    lslf_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DIV_GO),
        .i_num   (mac_acc),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequence the point and fit steps
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_PROD;
                end
            end
            S_PROD:  n_state = S_ACCUM;
            S_ACCUM: n_state = r_last ? S_FIT : S_IDLE;
            S_FIT:   n_state = (r_count == CW'(1)) ? S_OUT : S_MAC_GO;
            S_MAC_GO: n_state = S_MAC_WAIT;
            S_MAC_WAIT: begin
                if (mac_done) begin
                    case (r_op)
                        OP_DEN_B: n_state = S_CHECK;
                        OP_SLO_B: n_state = S_DIV_GO;
                        OP_INT_B: n_state = S_DIV_GO;
                        default:  n_state = S_MAC_GO;
                    endcase
                end
            end
            S_CHECK: begin
                if (mac_acc[NW-1] || (mac_acc == '0)) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MAC_GO;
                end
            end
            S_DIV_GO: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_done) begin
                    n_state = (r_op == OP_SLO_B) ? S_MAC_GO : S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Advance the pass index of the fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_DEN_A;
        end else begin
            case (r_state)
                S_FIT: r_op <= OP_DEN_A;
                S_MAC_WAIT: begin
                    if (mac_done) begin
                        case (r_op)
                            OP_DEN_A: r_op <= OP_DEN_B;
                            OP_SLO_A: r_op <= OP_SLO_B;
                            OP_INT_A: r_op <= OP_INT_B;
                            default:  r_op <= r_op;
                        endcase
                    end
                end
                S_CHECK: r_op <= OP_SLO_A;
                S_DIV_WAIT: begin
                    if (div_done && (r_op == OP_SLO_B)) begin
                        r_op <= OP_INT_A;
                    end
                end
                default: r_op <= r_op;
            endcase
        end
    end

    // Capture the point and form its products
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_x    <= s_axis_tdata[XW-1:0];
            r_y    <= $signed(s_axis_tdata[XW+YW-1:XW]);
            r_last <= s_axis_tlast;
        end
        if (r_state == S_PROD) begin
            r_pxx <= r_x * r_x;
            r_pxy <= $signed({1'b0, r_x}) * r_y;
        end
    end

    // Accumulate the sums; drop points past the limit; clear after each fit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || out_load) begin
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_xx <= '0;
            r_sum_y  <= '0;
            r_sum_xy <= '0;
            r_ovf    <= 1'b0;
        end else if (r_state == S_ACCUM) begin
            if (r_count < CW'(MAX_POINTS)) begin
                r_count  <= r_count + 1'b1;
                r_sum_x  <= r_sum_x + SXW'(r_x);
                r_sum_xx <= r_sum_xx + SXXW'(r_pxx);
                r_sum_y  <= r_sum_y + SYW'(r_y);
                r_sum_xy <= r_sum_xy + SXYW'(r_pxy);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Hold fit results and status
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_FIT: begin
                r_status <= r_ovf ? lslf_pkg::FIT_OVERFLOW : lslf_pkg::FIT_OK;
                r_slope  <= r_sum_y[QW-1:0];
                r_icpt   <= '0;
            end
            S_CHECK: begin
                r_den <= mac_acc[DW-1:0];
                if (mac_acc[NW-1] || (mac_acc == '0)) begin
                    r_status <= lslf_pkg::FIT_ZERO_DEN;
                    r_slope  <= '0;
                    r_icpt   <= '0;
                end
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    if (r_op == OP_SLO_B) begin
                        r_slope <= div_quot;
                    end else begin
                        r_icpt <= div_quot;
                    end
                end
            end
            default: r_den <= r_den;
        endcase
    end

    // Output register: load a finished fit, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_slope_o  <= r_slope;
            r_icpt_o   <= r_icpt;
            r_status_o <= r_status;
        end
    end

endmodule
